// ----- rtl/core/tsrtt_pkg.sv -----
// shared constants and types of the timestamp rtt estimator
`default_nettype none
package tsrtt_pkg;

  localparam int unsigned StoreDepthDefault = 16;

  localparam int unsigned TimeW  = 40;
  localparam int unsigned StampW = 32;
  localparam int unsigned SumW   = 41;
  localparam int unsigned TotalW = 56;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgW   = 40;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] RegMaxRtt   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOutlier  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegShift    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDataOnly = 2'd3;

  localparam logic [TimeW-1:0] MaxRttReset = 40'd20000000;
  localparam logic [3:0] OutlierReset = 4'd5;
  localparam logic [2:0] ShiftReset = 3'd2;
  localparam logic DataOnlyReset = 1'b1;

  // divider request / response between top and divider
  typedef struct packed {
    logic              start;
    logic [TotalW-1:0] dividend;
    logic [CountW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ----- rtl/core/tcp_timestamp_rtt_estimator_unit.sv -----
// top level: sequencer for echo lookup, stamp store, estimate update and averages
// a timestamped item walks the reverse store to the echoed stamp and, when its stamp
// is stored, its own store to refresh or append it; every item then runs the two
// 56-step mean divisions when both totals are nonzero; one item at a time
// the result sits in an output register; the next item is taken while it waits
// reset (rst_ni low, asynchronous) empties both stores and clears estimates,
// totals and counts; registers return to their defaults
`default_nettype none
module tcp_timestamp_rtt_estimator_unit #(
  parameter int unsigned StoreDepth = tsrtt_pkg::StoreDepthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tsrtt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [tsrtt_pkg::CfgW-1:0]      cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            direction_i,
  input  wire logic                            has_timestamp_i,
  input  wire logic [31:0]                     ts_value_i,
  input  wire logic [31:0]                     ts_echo_i,
  input  wire logic [39:0]                     arrival_us_i,
  input  wire logic                            carries_payload_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 sample_valid_o,
  output logic [39:0]                          rtt_sample_us_o,
  output logic [39:0]                          outside_estimate_us_o,
  output logic                                 outside_valid_o,
  output logic [39:0]                          inside_estimate_us_o,
  output logic                                 inside_valid_o,
  output logic [40:0]                          total_estimate_us_o,
  output logic [40:0]                          average_rtt_us_o,
  output logic                                 average_valid_o,
  output logic                                 entry_overwritten_o
);
  localparam int unsigned AW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned FW = $clog2(StoreDepth + 1);
  localparam int unsigned TW = tsrtt_pkg::TimeW;
  localparam int unsigned TOW = tsrtt_pkg::TotalW;
  localparam int unsigned CW = tsrtt_pkg::CountW;
  localparam logic [FW-1:0] DepthF = FW'(StoreDepth);
  localparam logic [AW-1:0] LastA = AW'(StoreDepth - 1);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StEchoRd = 4'd1;
  localparam logic [3:0] StEchoCk = 4'd2;
  localparam logic [3:0] StMul    = 4'd3;
  localparam logic [3:0] StEst    = 4'd4;
  localparam logic [3:0] StOwnRd  = 4'd5;
  localparam logic [3:0] StOwnCk  = 4'd6;
  localparam logic [3:0] StAppend = 4'd7;
  localparam logic [3:0] StDiv0   = 4'd8;
  localparam logic [3:0] StWait0  = 4'd9;
  localparam logic [3:0] StWait1  = 4'd10;
  localparam logic [3:0] StOut    = 4'd11;

  // configuration
  logic [TW-1:0] max_rtt_q;
  logic [3:0]    outlier_q;
  logic [2:0]    shift_q;
  logic          data_only_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rtt_q <= tsrtt_pkg::MaxRttReset;
      outlier_q <= tsrtt_pkg::OutlierReset;
      shift_q <= tsrtt_pkg::ShiftReset;
      data_only_q <= tsrtt_pkg::DataOnlyReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tsrtt_pkg::RegMaxRtt:   max_rtt_q <= cfg_data_i;
        tsrtt_pkg::RegOutlier:  outlier_q <= cfg_data_i[3:0];
        tsrtt_pkg::RegShift:    shift_q <= cfg_data_i[2:0];
        tsrtt_pkg::RegDataOnly: data_only_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // state
  logic [3:0]     st_q, st_d;
  logic [AW-1:0]  head_q [2];
  logic [AW-1:0]  head_d [2];
  logic [FW-1:0]  fill_q [2];
  logic [FW-1:0]  fill_d [2];
  logic [TW-1:0]  est_q [2];
  logic [TW-1:0]  est_d [2];
  logic [1:0]     seeded_q, seeded_d;
  logic [TOW-1:0] tot_q [2];
  logic [TOW-1:0] tot_d [2];
  logic [CW-1:0]  cnt_q [2];
  logic [CW-1:0]  cnt_d [2];

  // item
  logic           dir_q, dir_d;
  logic [31:0]    tsv_q, tsv_d;
  logic [31:0]    tse_q, tse_d;
  logic [TW-1:0]  now_q, now_d;
  logic           store_q, store_d;
  logic [FW-1:0]  idx_q, idx_d;
  logic           got_q, got_d;
  logic           lost_q, lost_d;
  logic [TW-1:0]  smp_q, smp_d;
  logic [TW+4:0]  lim_q, lim_d;
  logic [TW+7:0]  prod_q, prod_d;
  logic [TW-1:0]  mean0_q, mean0_d;
  logic [TW:0]    avg_q, avg_d;
  logic           avgv_q, avgv_d;

  // output register
  logic           ov_q, ov_d;
  logic           o_smp_v_q, o_smp_v_d;
  logic [TW-1:0]  o_smp_q, o_smp_d;
  logic [TW-1:0]  o_e0_q, o_e0_d, o_e1_q, o_e1_d;
  logic [TW:0]    o_tot_q, o_tot_d, o_avg_q, o_avg_d;
  logic           o_avgv_q, o_avgv_d, o_lost_q, o_lost_d;

  // memory port
  logic           rd_dir;
  logic [AW-1:0]  rd_addr;
  logic [31:0]    rd_stamp;
  logic [TW-1:0]  rd_time;
  logic           wr_en, wr_stamp_en;
  logic [AW-1:0]  wr_addr;

  tsrtt_pkg::div_req_t div_req;
  tsrtt_pkg::div_rsp_t div_rsp;

  tsrtt_store #(.StoreDepth(StoreDepth)) u_store (
    .clk_i         (clk_i),
    .rd_dir_i      (rd_dir),
    .rd_addr_i     (rd_addr),
    .rd_stamp_o    (rd_stamp),
    .rd_time_o     (rd_time),
    .wr_en_i       (wr_en),
    .wr_stamp_en_i (wr_stamp_en),
    .wr_dir_i      (dir_q),
    .wr_addr_i     (wr_addr),
    .wr_stamp_i    (tsv_q),
    .wr_time_i     (now_q)
  );

  tsrtt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [FW-1:0] b);
    logic [AW+FW:0] s;
    s = (AW+FW+1)'(a) + (AW+FW+1)'(b);
    if (s >= (AW+FW+1)'(StoreDepth)) begin
      s = s - (AW+FW+1)'(StoreDepth);
    end
    return s[AW-1:0];
  endfunction

  logic           rev;
  logic           accept;
  logic [TW:0]    tdiff;
  logic [TOW:0]   tot_sum;
  logic [TW+7:0]  mix;
  logic [TW:0]    e_sum;

  assign rev = ~dir_q;
  assign in_stall_o = (st_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    st_d = st_q;
    head_d = head_q;
    fill_d = fill_q;
    est_d = est_q;
    seeded_d = seeded_q;
    tot_d = tot_q;
    cnt_d = cnt_q;
    dir_d = dir_q;
    tsv_d = tsv_q;
    tse_d = tse_q;
    now_d = now_q;
    store_d = store_q;
    idx_d = idx_q;
    got_d = got_q;
    lost_d = lost_q;
    smp_d = smp_q;
    lim_d = lim_q;
    prod_d = prod_q;
    mean0_d = mean0_q;
    avg_d = avg_q;
    avgv_d = avgv_q;
    ov_d = ov_q;
    o_smp_v_d = o_smp_v_q;
    o_smp_d = o_smp_q;
    o_e0_d = o_e0_q;
    o_e1_d = o_e1_q;
    o_tot_d = o_tot_q;
    o_avg_d = o_avg_q;
    o_avgv_d = o_avgv_q;
    o_lost_d = o_lost_q;
    rd_dir = rev;
    rd_addr = head_q[rev];
    wr_en = 1'b0;
    wr_stamp_en = 1'b0;
    wr_addr = wrap_add(head_q[dir_q], idx_q);
    div_req.start = 1'b0;
    div_req.dividend = tot_q[0];
    div_req.divisor = cnt_q[0];
    tdiff = {1'b0, now_q} - {1'b0, rd_time};
    tot_sum = {1'b0, tot_q[rev]} + (TOW+1)'(smp_q);
    mix = prod_q + (TW+8)'(smp_q);
    e_sum = {1'b0, est_q[0]} + {1'b0, est_q[1]};

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (st_q)
      StIdle: begin
        if (accept) begin
          dir_d = direction_i;
          tsv_d = ts_value_i;
          tse_d = ts_echo_i;
          now_d = arrival_us_i;
          store_d = has_timestamp_i && (ts_value_i != '0)
                    && (!data_only_q || carries_payload_i);
          got_d = 1'b0;
          lost_d = 1'b0;
          smp_d = '0;
          st_d = has_timestamp_i ? StEchoRd : StDiv0;
        end
      end
      StEchoRd: begin
        // memory read of the reverse head is issued here
        st_d = (fill_q[rev] != '0) ? StEchoCk : StOwnRd;
        idx_d = '0;
      end
      StEchoCk: begin
        if (tse_q > rd_stamp) begin
          head_d[rev] = (head_q[rev] == LastA) ? '0 : head_q[rev] + 1'b1;
          fill_d[rev] = fill_q[rev] - 1'b1;
          st_d = StEchoRd;
        end else if (tse_q == rd_stamp && !tdiff[TW] && tdiff[TW-1:0] < max_rtt_q) begin
          got_d = 1'b1;
          smp_d = tdiff[TW-1:0];
          lim_d = (TW+5)'(est_q[rev]) * (TW+5)'(outlier_q);
          prod_d = (TW+8)'(est_q[rev]) * (TW+8)'((8'd1 << shift_q) - 8'd1);
          st_d = StMul;
        end else begin
          st_d = StOwnRd;
        end
      end
      StMul: begin
        tot_d[rev] = tot_sum[TOW] ? '1 : tot_sum[TOW-1:0];
        if (cnt_q[rev] != '1) begin
          cnt_d[rev] = cnt_q[rev] + 1'b1;
        end
        st_d = StEst;
      end
      StEst: begin
        if (!seeded_q[rev]) begin
          est_d[rev] = smp_q;
          seeded_d[rev] = 1'b1;
        end else if (outlier_q == '0 || (TW+5)'(smp_q) <= lim_q) begin
          est_d[rev] = TW'(mix >> shift_q);
        end
        st_d = StOwnRd;
      end
      StOwnRd: begin
        rd_dir = dir_q;
        rd_addr = wrap_add(head_q[dir_q], idx_q);
        if (!store_q) begin
          st_d = StDiv0;
        end else if (idx_q < fill_q[dir_q]) begin
          st_d = StOwnCk;
        end else begin
          st_d = StAppend;
        end
      end
      StOwnCk: begin
        rd_dir = dir_q;
        if (rd_stamp == tsv_q) begin
          wr_en = 1'b1;
          st_d = StDiv0;
        end else begin
          idx_d = idx_q + 1'b1;
          st_d = StOwnRd;
        end
      end
      StAppend: begin
        wr_en = 1'b1;
        wr_stamp_en = 1'b1;
        if (fill_q[dir_q] >= DepthF) begin
          // full: new entry lands in the oldest slot
          wr_addr = head_q[dir_q];
          head_d[dir_q] = (head_q[dir_q] == LastA) ? '0 : head_q[dir_q] + 1'b1;
          lost_d = 1'b1;
        end else begin
          wr_addr = wrap_add(head_q[dir_q], fill_q[dir_q]);
          fill_d[dir_q] = fill_q[dir_q] + 1'b1;
        end
        st_d = StDiv0;
      end
      StDiv0: begin
        if (tot_q[0] != '0 && tot_q[1] != '0) begin
          div_req.start = 1'b1;
          st_d = StWait0;
        end else begin
          mean0_d = '0;
          avg_d = '0;
          avgv_d = 1'b0;
          st_d = StOut;
        end
      end
      StWait0: begin
        if (div_rsp.done) begin
          mean0_d = div_rsp.quotient;
          div_req.start = 1'b1;
          div_req.dividend = tot_q[1];
          div_req.divisor = cnt_q[1];
          st_d = StWait1;
        end
      end
      StWait1: begin
        if (div_rsp.done) begin
          avg_d = {1'b0, mean0_q} + {1'b0, div_rsp.quotient};
          avgv_d = 1'b1;
          st_d = StOut;
        end
      end
      StOut: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          o_smp_v_d = got_q;
          o_smp_d = smp_q;
          o_e0_d = est_q[0];
          o_e1_d = est_q[1];
          o_tot_d = (est_q[0] != '0 && est_q[1] != '0) ? e_sum : '0;
          o_avg_d = avg_q;
          o_avgv_d = avgv_q;
          o_lost_d = lost_q;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      head_q <= '{default: '0};
      fill_q <= '{default: '0};
      est_q <= '{default: '0};
      seeded_q <= '0;
      tot_q <= '{default: '0};
      cnt_q <= '{default: '0};
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      head_q <= head_d;
      fill_q <= fill_d;
      est_q <= est_d;
      seeded_q <= seeded_d;
      tot_q <= tot_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dir_q <= dir_d;
    tsv_q <= tsv_d;
    tse_q <= tse_d;
    now_q <= now_d;
    store_q <= store_d;
    idx_q <= idx_d;
    got_q <= got_d;
    lost_q <= lost_d;
    smp_q <= smp_d;
    lim_q <= lim_d;
    prod_q <= prod_d;
    mean0_q <= mean0_d;
    avg_q <= avg_d;
    avgv_q <= avgv_d;
    o_smp_v_q <= o_smp_v_d;
    o_smp_q <= o_smp_d;
    o_e0_q <= o_e0_d;
    o_e1_q <= o_e1_d;
    o_tot_q <= o_tot_d;
    o_avg_q <= o_avg_d;
    o_avgv_q <= o_avgv_d;
    o_lost_q <= o_lost_d;
  end

  assign out_valid_o = ov_q;
  assign sample_valid_o = o_smp_v_q;
  assign rtt_sample_us_o = o_smp_q;
  assign outside_estimate_us_o = o_e0_q;
  assign outside_valid_o = (o_e0_q != '0);
  assign inside_estimate_us_o = o_e1_q;
  assign inside_valid_o = (o_e1_q != '0);
  assign total_estimate_us_o = o_tot_q;
  assign average_rtt_us_o = o_avg_q;
  assign average_valid_o = o_avgv_q;
  assign entry_overwritten_o = o_lost_q;
endmodule
`default_nettype wire

// ----- rtl/core/tsrtt_div.sv -----
// restoring divider, one quotient bit per cycle, saturating the mean at 40 bits
`default_nettype none
module tsrtt_div (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tsrtt_pkg::div_req_t req_i,
  output tsrtt_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned TW = tsrtt_pkg::TotalW;
  localparam int unsigned CW = tsrtt_pkg::CountW;
  localparam int unsigned NW = $clog2(TW + 1);

  logic [TW-1:0] quo_q, quo_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] dvs_q, dvs_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW:0]   trial;
  logic [CW+1:0] diff;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q, quo_q[TW-1]};
    diff = {1'b0, trial} - {2'b00, dvs_q};
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = NW'(TW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // the remainder stays below the divisor, so it fits in CW bits
      if (!diff[CW+1]) begin
        rem_d = diff[CW-1:0];
        quo_d = {quo_q[TW-2:0], 1'b1};
      end else begin
        rem_d = trial[CW-1:0];
        quo_d = {quo_q[TW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == NW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = (|quo_q[TW-1:tsrtt_pkg::TimeW]) ? '1
                                                         : quo_q[tsrtt_pkg::TimeW-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/tsrtt_store.sv -----
// per-direction stamp/time memory with a registered read
`default_nettype none
module tsrtt_store #(
  parameter int unsigned StoreDepth = tsrtt_pkg::StoreDepthDefault,
  localparam int unsigned AW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rd_dir_i,
  input  wire logic [AW-1:0]                 rd_addr_i,
  output logic [tsrtt_pkg::StampW-1:0]       rd_stamp_o,
  output logic [tsrtt_pkg::TimeW-1:0]        rd_time_o,
  input  wire logic                          wr_en_i,
  input  wire logic                          wr_stamp_en_i,
  input  wire logic                          wr_dir_i,
  input  wire logic [AW-1:0]                 wr_addr_i,
  input  wire logic [tsrtt_pkg::StampW-1:0]  wr_stamp_i,
  input  wire logic [tsrtt_pkg::TimeW-1:0]   wr_time_i
);
  // one half per direction, each half padded to a power of two
  logic [tsrtt_pkg::StampW-1:0] stamp_mem [2**(AW+1)];
  logic [tsrtt_pkg::TimeW-1:0]  time_mem  [2**(AW+1)];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      time_mem[{wr_dir_i, wr_addr_i}] <= wr_time_i;
      if (wr_stamp_en_i) begin
        stamp_mem[{wr_dir_i, wr_addr_i}] <= wr_stamp_i;
      end
    end
    rd_stamp_o <= stamp_mem[{rd_dir_i, rd_addr_i}];
    rd_time_o <= time_mem[{rd_dir_i, rd_addr_i}];
  end
endmodule
`default_nettype wire

// ----- test/tb_tcp_timestamp_rtt_estimator_unit.sv -----
// testbench of the timestamp rtt estimator: directed packets, register sweeps, random traffic
`default_nettype none
module tb_tcp_timestamp_rtt_estimator_unit;

  localparam int unsigned Depth = 16;
  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned CfgW = tsrtt_pkg::CfgW;
  localparam int unsigned CfgIdxW = tsrtt_pkg::CfgIdxW;
  localparam logic [39:0] Mask40 = 40'hFF_FFFF_FFFF;
  localparam logic [63:0] Mask56 = 64'h00FF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        sample_valid;
    logic [39:0] rtt_sample;
    logic [39:0] outside_est;
    logic        outside_ok;
    logic [39:0] inside_est;
    logic        inside_ok;
    logic [40:0] total_est;
    logic [40:0] average;
    logic        average_ok;
    logic        overwritten;
  } rtt_result_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic direction_i, has_timestamp_i, carries_payload_i;
  logic [31:0] ts_value_i, ts_echo_i;
  logic [39:0] arrival_us_i;
  logic out_valid_o, out_stall_i;
  logic sample_valid_o, outside_valid_o, inside_valid_o, average_valid_o, entry_overwritten_o;
  logic [39:0] rtt_sample_us_o, outside_estimate_us_o, inside_estimate_us_o;
  logic [40:0] total_estimate_us_o, average_rtt_us_o;

  tcp_timestamp_rtt_estimator_unit #(.StoreDepth(Depth)) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .direction_i, .has_timestamp_i, .ts_value_i, .ts_echo_i,
    .arrival_us_i, .carries_payload_i, .out_valid_o, .out_stall_i,
    .sample_valid_o, .rtt_sample_us_o, .outside_estimate_us_o, .outside_valid_o,
    .inside_estimate_us_o, .inside_valid_o, .total_estimate_us_o, .average_rtt_us_o,
    .average_valid_o, .entry_overwritten_o
  );

  // predictor state
  logic [39:0] max_rtt;
  logic [3:0]  outlier_mult;
  logic [2:0]  shift;
  logic        data_only;
  logic [31:0] stamps [2][Depth];
  logic [39:0] stamp_times [2][Depth];
  int unsigned head [2];
  int unsigned fill [2];
  logic [63:0] estimate [2];
  logic        seeded [2];
  logic [63:0] total [2];
  logic [63:0] count [2];

  rtt_result_t expected_rtts[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit quiet;

  // random traffic bookkeeping
  logic [31:0] next_stamp [2];
  logic [31:0] sent_stamps [2][$];
  logic [39:0] clock_us;

  function automatic void fold_sample(int unsigned d, logic [63:0] diff);
    logic [63:0] est;
    est = estimate[d];
    total[d] = total[d] + diff;
    if (total[d] > Mask56) total[d] = Mask56;
    if (count[d] < 64'hFFFF_FFFF) count[d]++;
    if (!seeded[d]) begin
      estimate[d] = diff;
      seeded[d] = 1'b1;
    end else if (!(outlier_mult != 0 && diff > est * outlier_mult)) begin
      estimate[d] = ((est * ((64'd1 << shift) - 1) + diff) >> shift) & Mask40;
    end
  endfunction

  function automatic logic [63:0] mean_rtt(int unsigned d);
    logic [63:0] m;
    if (count[d] == 0) return 0;
    m = total[d] / count[d];
    return (m > Mask40) ? Mask40 : m;
  endfunction

  function automatic rtt_result_t predict_rtt(logic d, logic ht, logic [31:0] v,
                                              logic [31:0] e, logic [39:0] t, logic p);
    rtt_result_t r;
    int unsigned own, rev, pos;
    logic [63:0] diff;
    bit found;
    own = d;
    rev = 1 - own;
    r = '0;
    if (ht) begin
      // drop entries older than the echo; an exact match below the limit gives a sample
      while (fill[rev] > 0) begin
        pos = head[rev];
        if (e > stamps[rev][pos]) begin
          head[rev] = (pos + 1) % Depth;
          fill[rev]--;
        end else begin
          if (e == stamps[rev][pos] && t >= stamp_times[rev][pos]) begin
            diff = t - stamp_times[rev][pos];
            if (diff < max_rtt) begin
              fold_sample(rev, diff);
              r.sample_valid = 1'b1;
              r.rtt_sample = diff[39:0];
            end
          end
          break;
        end
      end
      if (v != 0 && (!data_only || p)) begin
        found = 0;
        for (int unsigned i = 0; i < fill[own]; i++) begin
          pos = (head[own] + i) % Depth;
          if (!found && stamps[own][pos] == v) begin
            stamp_times[own][pos] = t;
            found = 1;
          end
        end
        if (!found) begin
          if (fill[own] >= Depth) begin
            head[own] = (head[own] + 1) % Depth;
            fill[own] = Depth - 1;
            r.overwritten = 1'b1;
          end
          pos = (head[own] + fill[own]) % Depth;
          stamps[own][pos] = v;
          stamp_times[own][pos] = t;
          fill[own]++;
        end
      end
    end
    r.outside_ok = estimate[0] > 0;
    r.inside_ok = estimate[1] > 0;
    r.outside_est = r.outside_ok ? estimate[0][39:0] : '0;
    r.inside_est = r.inside_ok ? estimate[1][39:0] : '0;
    r.total_est = (r.outside_ok && r.inside_ok) ? 41'(estimate[0] + estimate[1]) : '0;
    r.average_ok = total[0] > 0 && total[1] > 0;
    r.average = r.average_ok ? 41'(mean_rtt(0) + mean_rtt(1)) : '0;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic send_packet(logic d, logic ht, logic [31:0] v, logic [31:0] e,
                             logic [39:0] t, logic p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    direction_i <= d;
    has_timestamp_i <= ht;
    ts_value_i <= v;
    ts_echo_i <= e;
    arrival_us_i <= t;
    carries_payload_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_rtts.push_back(predict_rtt(d, ht, v, e, t, p));
  endtask

  // hold off until every result is back and the block has gone idle
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_rtts.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tsrtt_pkg::RegMaxRtt:   max_rtt = value[39:0];
      tsrtt_pkg::RegOutlier:  outlier_mult = value[3:0];
      tsrtt_pkg::RegShift:    shift = value[2:0];
      tsrtt_pkg::RegDataOnly: data_only = value[0];
      default: ;
    endcase
  endtask

  task automatic random_packet;
    logic d, ht, p;
    logic [31:0] v, e;
    logic [39:0] t;
    int unsigned rev;
    d = 1'($urandom_range(0, 1));
    rev = 1 - d;
    ht = $urandom_range(0, 9) != 0;
    p = $urandom_range(0, 4) != 0;
    clock_us = clock_us + 40'($urandom_range(0, 40));
    t = ($urandom_range(0, 49) == 0) ? 40'({$urandom, $urandom}) : clock_us;
    case ($urandom_range(0, 19))
      0: v = 0;
      1, 2: v = $urandom;
      default: begin
        next_stamp[d] = next_stamp[d] + $urandom_range(1, 3);
        v = next_stamp[d];
      end
    endcase
    if (sent_stamps[rev].size() != 0 && $urandom_range(0, 4) != 0)
      e = sent_stamps[rev][$urandom_range(0, sent_stamps[rev].size() - 1)];
    else
      e = $urandom;
    if (v != 0) begin
      sent_stamps[d].push_back(v);
      if (sent_stamps[d].size() > 6) void'(sent_stamps[d].pop_front());
    end
    send_packet(d, ht, v, e, t, p);
  endtask

  task automatic test_directed_cases;
    send_packet(1'b0, 1'b0, 32'd5, 32'd0, 40'd900, 1'b1);           // no option at all
    send_packet(1'b0, 1'b1, 32'd100, 32'd0, 40'd1000, 1'b1);
    send_packet(1'b0, 1'b1, 32'd100, 32'd0, 40'd1010, 1'b1);        // refresh of a stored stamp
    send_packet(1'b0, 1'b1, 32'd0, 32'd0, 40'd1020, 1'b1);          // no tsval
    send_packet(1'b0, 1'b1, 32'd200, 32'd0, 40'd1030, 1'b0);        // pure ack, not stored
    send_packet(1'b1, 1'b1, 32'd500, 32'd100, 40'd1050, 1'b1);      // first sample seeds outside
    send_packet(1'b0, 1'b1, 32'd300, 32'd500, 40'd1050, 1'b1);
    send_packet(1'b1, 1'b1, 32'd600, 32'd300, 40'd1050, 1'b1);      // zero sample lowers outside
    send_packet(1'b0, 1'b1, 32'd400, 32'd600, 40'd1100, 1'b1);
    send_packet(1'b1, 1'b1, 32'd700, 32'd400, 40'd1200, 1'b1);      // sample within the outlier bound
    send_packet(1'b0, 1'b1, 32'd410, 32'd700, 40'd5000, 1'b1);
    send_packet(1'b1, 1'b1, 32'd710, 32'd410, 40'd4000, 1'b1);      // arrival earlier than stamp
    send_packet(1'b0, 1'b1, 32'd800, 32'd710, 40'd10000, 1'b1);
    send_packet(1'b1, 1'b1, 32'd720, 32'd800, 40'd5010000, 1'b1);   // large sample
    send_packet(1'b0, 1'b1, 32'd900, 32'd720, 40'd20000000, 1'b1);
    send_packet(1'b1, 1'b1, 32'd730, 32'd900, 40'd40000000, 1'b1);  // sample equal to the limit
    send_packet(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd0, 40'hFF_FFFF_FF00, 1'b1);
    send_packet(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Mask40, 1'b1);
    for (int i = 0; i < 17; i++)                                    // overflow the inside store
      send_packet(1'b1, 1'b1, 32'd2000 + i, 32'd0, 40'd60000 + i, 1'b1);
    send_packet(1'b0, 1'b1, 32'd950, 32'd2010, 40'd60100, 1'b1);    // echo drops older entries
  endtask

  task automatic test_register_settings;
    logic [39:0] max_list [6] = '{40'd1, 40'd0, Mask40, 40'd1000, 40'd30, 40'd20000000};
    logic [3:0] mult_list [6] = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd0, 4'd5};
    logic [2:0] shift_list [6] = '{3'd7, 3'd1, 3'd0, 3'd3, 3'd5, 3'd2};
    logic do_list [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(tsrtt_pkg::RegMaxRtt, max_list[ph]);
      write_reg(tsrtt_pkg::RegOutlier, CfgW'(mult_list[ph]));
      write_reg(tsrtt_pkg::RegShift, CfgW'(shift_list[ph]));
      write_reg(tsrtt_pkg::RegDataOnly, CfgW'(do_list[ph]));
      repeat (170) random_packet();
    end
  endtask

  task automatic test_steady_traffic;
    drain();
    quiet = 1;
    repeat (100) random_packet();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    direction_i = 1'b0;
    has_timestamp_i = 1'b0;
    ts_value_i = '0;
    ts_echo_i = '0;
    arrival_us_i = '0;
    carries_payload_i = 1'b0;
    quiet = 0;
    mismatches = 0;
    max_rtt = tsrtt_pkg::MaxRttReset;
    outlier_mult = tsrtt_pkg::OutlierReset;
    shift = tsrtt_pkg::ShiftReset;
    data_only = tsrtt_pkg::DataOnlyReset;
    for (int d = 0; d < 2; d++) begin
      head[d] = 0;
      fill[d] = 0;
      estimate[d] = 0;
      seeded[d] = 0;
      total[d] = 0;
      count[d] = 0;
      next_stamp[d] = $urandom_range(1, 1000);
    end
    clock_us = 40'd100;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_register_settings();
    test_steady_traffic();
    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver stalls
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [40:0] want, logic [40:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h got %0h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    rtt_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rtts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: unexpected result item");
      end else begin
        want = expected_rtts.pop_front();
        check_field("sample_valid", 41'(want.sample_valid), 41'(sample_valid_o));
        check_field("rtt_sample_us", 41'(want.rtt_sample), 41'(rtt_sample_us_o));
        check_field("outside_estimate_us", 41'(want.outside_est),
                    41'(outside_estimate_us_o));
        check_field("outside_valid", 41'(want.outside_ok), 41'(outside_valid_o));
        check_field("inside_estimate_us", 41'(want.inside_est), 41'(inside_estimate_us_o));
        check_field("inside_valid", 41'(want.inside_ok), 41'(inside_valid_o));
        check_field("total_estimate_us", want.total_est, total_estimate_us_o);
        check_field("average_rtt_us", want.average, average_rtt_us_o);
        check_field("average_valid", 41'(want.average_ok), 41'(average_valid_o));
        check_field("entry_overwritten", 41'(want.overwritten), 41'(entry_overwritten_o));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/core/tsrtt_pkg.sv
rtl/core/tsrtt_div.sv
rtl/core/tsrtt_store.sv
rtl/core/tcp_timestamp_rtt_estimator_unit.sv
test/tb_tcp_timestamp_rtt_estimator_unit.sv
